FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

FILE: src/lzts_pkg.sv
// ----------------------------------------------------------------------------
// lzts_pkg
// Types and constants shared by the LZ77 token scanner modules.
// ----------------------------------------------------------------------------
package lzts_pkg;

	localparam int unsigned CNT_W   = 25;
	localparam int unsigned TGT_W   = 24;
	localparam int unsigned DISP_W  = 12;
	localparam int unsigned LEN_W   = 5;
	localparam int unsigned KIND_W  = 2;

	// token kinds
	localparam logic [KIND_W-1:0] KIND_LIT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MAT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END = 2'd2;

	localparam logic [LEN_W-1:0] LEN_BIAS    = 5'd3;
	localparam logic [3:0]       FLAG_TOKENS = 4'd8;
	localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};

	typedef struct packed {
		logic              emit;
		logic [KIND_W-1:0] kind;
		logic [7:0]        literal;
		logic [LEN_W-1:0]  length;
		logic [DISP_W-1:0] disp;
		logic [CNT_W-1:0]  total;
		logic [CNT_W-1:0]  consumed;
		logic              last;
	} lzts_result_t;

endpackage

FILE: src/lzts_core.sv
// ----------------------------------------------------------------------------
// lzts_core
// Scanner state and per-beat token decode; yields at most one result a beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzts_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 beat,
	input  logic [7:0]           data_byte,
	input  logic                 stream_start,
	output lzts_pkg::lzts_result_t res
);
	import lzts_pkg::*;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_FLAG   = 3'd2;
	localparam logic [2:0] PH_TOKEN  = 3'd3;
	localparam logic [2:0] PH_MATCH2 = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	logic [2:0]       phase_q,    phase_nxt;
	logic [1:0]       hdr_cnt_q,  hdr_cnt_nxt;
	logic [TGT_W-1:0] target_q,   target_nxt;
	logic [7:0]       flags_q,    flags_nxt;
	logic [3:0]       tokens_q,   tokens_nxt;
	logic [7:0]       mhb_q,      mhb_nxt;
	logic [CNT_W-1:0] total_q,    total_nxt;
	logic [CNT_W-1:0] consumed_q, consumed_nxt;

	logic             tok_done;
	logic [LEN_W-1:0] tok_add;
	logic [LEN_W-1:0] mat_len;
	logic [CNT_W-1:0] consumed_inc;

	assign mat_len      = {1'b0, mhb_q[7:4]} + LEN_BIAS;
	assign consumed_inc = (consumed_q == CNT_MAX) ? consumed_q : consumed_q + 1'b1;

	always_comb begin
		phase_nxt    = phase_q;
		hdr_cnt_nxt  = hdr_cnt_q;
		target_nxt   = target_q;
		flags_nxt    = flags_q;
		tokens_nxt   = tokens_q;
		mhb_nxt      = mhb_q;
		total_nxt    = total_q;
		consumed_nxt = consumed_q;
		tok_done     = 1'b0;
		tok_add      = '0;
		res          = '0;

		if (beat) begin
			if (stream_start) begin
				// restart: this beat is the ignored type byte
				phase_nxt    = PH_HEADER;
				hdr_cnt_nxt  = 2'd1;
				target_nxt   = '0;
				flags_nxt    = '0;
				tokens_nxt   = '0;
				mhb_nxt      = '0;
				total_nxt    = '0;
				consumed_nxt = '0;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						case (hdr_cnt_q)
							2'd1:    target_nxt[7:0]   = data_byte;
							2'd2:    target_nxt[15:8]  = data_byte;
							2'd3:    target_nxt[23:16] = data_byte;
							default: ;
						endcase
						hdr_cnt_nxt = hdr_cnt_q + 2'd1;
						if (hdr_cnt_nxt == 2'd0) begin
							if (target_nxt == '0) begin
								phase_nxt    = PH_DONE;
								res.emit     = 1'b1;
								res.kind     = KIND_END;
								res.last     = 1'b1;
								res.total    = total_q;
								res.consumed = consumed_q;
							end else begin
								phase_nxt = PH_FLAG;
							end
						end
					end
					PH_FLAG: begin
						consumed_nxt = consumed_inc;
						flags_nxt    = data_byte;
						tokens_nxt   = FLAG_TOKENS;
						phase_nxt    = PH_TOKEN;
					end
					PH_TOKEN: begin
						consumed_nxt = consumed_inc;
						if (!flags_q[7]) begin
							tok_done    = 1'b1;
							tok_add     = LEN_W'(1);
							res.kind    = KIND_LIT;
							res.literal = data_byte;
						end else begin
							mhb_nxt   = data_byte;
							phase_nxt = PH_MATCH2;
						end
					end
					PH_MATCH2: begin
						consumed_nxt = consumed_inc;
						tok_done     = 1'b1;
						tok_add      = mat_len;
						res.kind     = KIND_MAT;
						res.length   = mat_len;
						res.disp     = {mhb_q[3:0], data_byte};
					end
					default: ;
				endcase

				// close out a literal or match token
				if (tok_done) begin
					total_nxt  = total_q + CNT_W'(tok_add);
					flags_nxt  = {flags_q[6:0], 1'b0};
					tokens_nxt = (tokens_q == 4'd0) ? tokens_q : tokens_q - 4'd1;
					if (total_nxt >= {1'b0, target_q}) begin
						phase_nxt = PH_DONE;
						res.last  = 1'b1;
					end else begin
						phase_nxt = (tokens_nxt == 4'd0) ? PH_FLAG : PH_TOKEN;
					end
					res.emit     = 1'b1;
					res.total    = total_nxt;
					res.consumed = consumed_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			hdr_cnt_q  <= '0;
			target_q   <= '0;
			flags_q    <= '0;
			tokens_q   <= '0;
			mhb_q      <= '0;
			total_q    <= '0;
			consumed_q <= '0;
		end else begin
			phase_q    <= phase_nxt;
			hdr_cnt_q  <= hdr_cnt_nxt;
			target_q   <= target_nxt;
			flags_q    <= flags_nxt;
			tokens_q   <= tokens_nxt;
			mhb_q      <= mhb_nxt;
			total_q    <= total_nxt;
			consumed_q <= consumed_nxt;
		end
	end

	// a final token parks the scanner until the next stream start
	`ASSERT_CLK(a_last_parks, clk, arst_n, beat && res.emit && res.last |=> phase_q == PH_DONE, "last token did not park scanner")
	// matches always carry a biased length and no literal byte
	`ASSERT_CLK(a_match_shape, clk, arst_n, res.emit && res.kind == KIND_MAT |-> res.length >= LEN_BIAS && res.literal == 8'd0, "malformed match result")
	// last only once the target is met
	`ASSERT_CLK(a_last_target, clk, arst_n, res.emit && res.last && res.kind != KIND_END |-> res.total >= {1'b0, target_q}, "last before target reached")
	// byte count only moves back on a stream restart
	`ASSERT_CLK(a_cons_mono, clk, arst_n, beat && !stream_start |=> consumed_q >= $past(consumed_q), "consumed count went backwards")

endmodule

FILE: src/lz77_token_stream_scanner_unit.sv
// ----------------------------------------------------------------------------
// lz77_token_stream_scanner_unit - LZ77 compressed byte stream token scanner
// Latency: a result is on the token port the cycle after its final byte beat.
// Throughput: one byte beat per cycle, stalled while an untaken token waits.
// Reset: arst_n clears scanner state to idle and empties the output register.
// ----------------------------------------------------------------------------
module lz77_token_stream_scanner_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// byte channel
	input  logic                        data_valid,
	output logic                        data_ready,
	input  logic [7:0]                  data_byte,
	input  logic                        stream_start,
	// token channel
	output logic                        token_valid,
	input  logic                        token_ready,
	output logic [lzts_pkg::KIND_W-1:0] token_kind,
	output logic [7:0]                  literal_value,
	output logic [lzts_pkg::LEN_W-1:0]  match_length,
	output logic [lzts_pkg::DISP_W-1:0] match_displacement,
	output logic [lzts_pkg::CNT_W-1:0]  decoded_total,
	output logic [lzts_pkg::CNT_W-1:0]  bytes_consumed,
	output logic                        last
);
	import lzts_pkg::*;

	logic         beat;
	lzts_result_t res;
	logic         valid_q;
	lzts_result_t out_q;

	// Take a new byte whenever the output slot is free or being drained this
	// cycle, so a full register never holds the stream back by a bubble.
	assign data_ready = !valid_q || token_ready;
	assign beat       = data_valid && data_ready;

	lzts_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.beat         (beat),
		.data_byte    (data_byte),
		.stream_start (stream_start),
		.res          (res)
	);

	// Output valid: set by a result-bearing beat, cleared once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (beat && res.emit) begin
			valid_q <= 1'b1;
		end else if (token_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload: loaded only with a fresh result; no reset needed.
	always_ff @(posedge clk) begin
		if (beat && res.emit) begin
			out_q <= res;
		end
	end

	assign token_valid        = valid_q;
	assign token_kind         = out_q.kind;
	assign literal_value      = out_q.literal;
	assign match_length       = out_q.length;
	assign match_displacement = out_q.disp;
	assign decoded_total      = out_q.total;
	assign bytes_consumed     = out_q.consumed;
	assign last               = out_q.last;

endmodule
